### rtl/core/plcb_pkg.sv
// shared types, codes and helpers for the pixel layer compositor
`timescale 1ns / 1ps

package plcb_pkg;

  localparam int NUM_BG     = 4;
  localparam int NUM_LAYERS = 5;
  localparam int COLOR_W    = 15;
  localparam int LAYER_W    = 3;
  localparam int WEIGHT_W   = 5;
  localparam int CHAN_W     = 5;
  localparam int KEY_W      = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [LAYER_W-1:0]   LAYER_SPRITE   = 3'd4;
  localparam logic [LAYER_W-1:0]   LAYER_BACKDROP = 3'd5;
  localparam logic [WEIGHT_W-1:0]  WEIGHT_FULL    = 5'd16;
  localparam logic [CHAN_W-1:0]    CHAN_MAX       = 5'd31;
  localparam logic [COLOR_W-1:0]   COLOR_WHITE    = 15'h7FFF;
  localparam logic [7:0]           ALPHA_OPAQUE   = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAYER_ENABLE   = 3'd0,
    REG_BG_PRIORITIES  = 3'd1,
    REG_BG_FIRST       = 3'd2,
    REG_BG_LAST        = 3'd3,
    REG_WIN_INSIDE     = 3'd4,
    REG_WIN_OUTSIDE    = 3'd5,
    REG_BLEND_CONTROL  = 3'd6,
    REG_BLEND_WEIGHTS  = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BLEND_NONE     = 2'd0,
    BLEND_ALPHA    = 2'd1,
    BLEND_BRIGHTEN = 2'd2,
    BLEND_DARKEN   = 2'd3
  } blend_mode_t;

  typedef struct packed {
    logic [NUM_LAYERS-1:0]              vis;
    logic [NUM_LAYERS-1:0][KEY_W-1:0]   key;
    logic [NUM_LAYERS-1:0][COLOR_W-1:0] col;
    logic [COLOR_W-1:0]                 backdrop;
    logic                               semi;
    logic                               fx_allow;
  } s1_data_t;

  typedef struct packed {
    logic [LAYER_W-1:0] top;
    logic [LAYER_W-1:0] second;
    logic [COLOR_W-1:0] pix0;
    logic [COLOR_W-1:0] pix1;
    logic               semi;
    logic               fx_allow;
  } s2_data_t;

  typedef struct packed {
    logic [LAYER_W-1:0]  top;
    logic [COLOR_W-1:0]  c1;
    logic [COLOR_W-1:0]  c2;
    logic [WEIGHT_W-1:0] w1;
    logic [WEIGHT_W-1:0] w2;
  } s3_data_t;

  function automatic logic [WEIGHT_W-1:0] clamp_weight(input logic [WEIGHT_W-1:0] v);
    logic [WEIGHT_W-1:0] r;
    r = (v > WEIGHT_FULL) ? WEIGHT_FULL : v;
    return r;
  endfunction

  function automatic logic [CHAN_W-1:0] mix_chan(input logic [CHAN_W-1:0] c1,
                                                  input logic [WEIGHT_W-1:0] w1,
                                                  input logic [CHAN_W-1:0] c2,
                                                  input logic [WEIGHT_W-1:0] w2);
    logic [CHAN_W+WEIGHT_W-1:0] p1;
    logic [CHAN_W+WEIGHT_W-1:0] p2;
    logic [CHAN_W+WEIGHT_W:0]   sum;
    logic [CHAN_W+WEIGHT_W-4:0] shifted;
    logic [CHAN_W-1:0]          r;
    p1      = {{WEIGHT_W{1'b0}}, c1} * {{CHAN_W{1'b0}}, w1};
    p2      = {{WEIGHT_W{1'b0}}, c2} * {{CHAN_W{1'b0}}, w2};
    sum     = {1'b0, p1} + {1'b0, p2};
    shifted = sum[CHAN_W+WEIGHT_W:4];
    r = (shifted > {{(WEIGHT_W-3){1'b0}}, CHAN_MAX}) ? CHAN_MAX : shifted[CHAN_W-1:0];
    return r;
  endfunction

endpackage

### rtl/core/pixel_layer_compositor_blend.sv
// pixel layer compositor: window select, priority sort, color effects, argb out
// four register stages lie between input transfer and result transfer
// throughput: one pixel per cycle, limited only by the per-stage handshake
// stages: window/visibility, top-two priority sort, effect select, channel mix
// reset: synchronous active-low rst_n clears all stage valids and loads the
// configuration registers with their defaults (bg_last = 3, all others 0)
`timescale 1ns / 1ps

module pixel_layer_compositor_blend
  import plcb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [15:0]           in_bg0_color,
  input  logic [15:0]           in_bg1_color,
  input  logic [15:0]           in_bg2_color,
  input  logic [15:0]           in_bg3_color,
  input  logic [15:0]           in_obj_color,
  input  logic [1:0]            in_obj_priority,
  input  logic                  in_obj_semi_transparent,
  input  logic                  in_obj_window,
  input  logic                  in_in_win0,
  input  logic                  in_in_win1,
  input  logic [COLOR_W-1:0]    in_backdrop_color,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           out_color,
  output logic [LAYER_W-1:0]    out_top_layer
);

  // configuration registers
  logic [7:0]  layer_en_r;
  logic [7:0]  bg_prio_r;
  logic [1:0]  bg_first_r;
  logic [1:0]  bg_last_r;
  logic [11:0] win_in_r;
  logic [11:0] win_out_r;
  logic [13:0] blend_ctl_r;
  logic [14:0] blend_wt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layer_en_r  <= '0;
      bg_prio_r   <= '0;
      bg_first_r  <= 2'd0;
      bg_last_r   <= 2'd3;
      win_in_r    <= '0;
      win_out_r   <= '0;
      blend_ctl_r <= '0;
      blend_wt_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LAYER_ENABLE:  layer_en_r  <= cfg_data[7:0];
        REG_BG_PRIORITIES: bg_prio_r   <= cfg_data[7:0];
        REG_BG_FIRST:      bg_first_r  <= cfg_data[1:0];
        REG_BG_LAST:       bg_last_r   <= cfg_data[1:0];
        REG_WIN_INSIDE:    win_in_r    <= cfg_data[11:0];
        REG_WIN_OUTSIDE:   win_out_r   <= cfg_data[11:0];
        REG_BLEND_CONTROL: blend_ctl_r <= cfg_data[13:0];
        REG_BLEND_WEIGHTS: blend_wt_r  <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // stage handshake
  logic     s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  logic     s1_rdy, s2_rdy, s3_rdy, s4_rdy;
  s1_data_t s1_r, s1_nxt;
  s2_data_t s2_r, s2_nxt;
  s3_data_t s3_r, s3_nxt;
  logic [31:0]        color_r, color_nxt;
  logic [LAYER_W-1:0] top_r;

  assign s4_rdy   = !s4_valid_r || !out_stall;
  assign s3_rdy   = !s3_valid_r || s4_rdy;
  assign s2_rdy   = !s2_valid_r || s3_rdy;
  assign s1_rdy   = !s1_valid_r || s2_rdy;
  assign in_stall = !s1_rdy;

  // stage 1: window choice and layer visibility
  always_comb begin
    logic [5:0]                         allow;
    logic [NUM_BG-1:0][15:0]            bgc;
    logic [1:0]                         prio;
    logic [1:0]                         bidx;
    bgc = {in_bg3_color, in_bg2_color, in_bg1_color, in_bg0_color};
    if (layer_en_r[5] && in_in_win0) begin
      allow = win_in_r[5:0];
    end else if (layer_en_r[6] && in_in_win1) begin
      allow = win_in_r[11:6];
    end else if (layer_en_r[7] && in_obj_window) begin
      allow = win_out_r[11:6];
    end else begin
      allow = win_out_r[5:0];
    end
    if (layer_en_r[7:5] == 3'b000) begin
      allow = 6'h3F;
    end
    for (int b = 0; b < NUM_BG; b++) begin
      bidx = 2'(b);
      prio = bg_prio_r[2*b +: 2];
      s1_nxt.vis[b] = layer_en_r[b] && allow[b] && !bgc[b][15] &&
                      (bidx >= bg_first_r) && (bidx <= bg_last_r);
      // later in scan order means smaller key
      s1_nxt.key[b] = {~prio, 1'b0, ~bidx};
      s1_nxt.col[b] = bgc[b][COLOR_W-1:0];
    end
    s1_nxt.vis[LAYER_SPRITE] = layer_en_r[4] && allow[4] && !in_obj_color[15];
    s1_nxt.key[LAYER_SPRITE] = {~in_obj_priority, 3'b100};
    s1_nxt.col[LAYER_SPRITE] = in_obj_color[COLOR_W-1:0];
    s1_nxt.backdrop = in_backdrop_color;
    s1_nxt.semi     = in_obj_semi_transparent;
    s1_nxt.fx_allow = allow[5];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_r <= s1_nxt;
    end
  end

  // stage 2: top two visible layers by rank
  always_comb begin
    logic [NUM_LAYERS-1:0][2:0] rank;
    s2_nxt.top      = LAYER_BACKDROP;
    s2_nxt.second   = LAYER_BACKDROP;
    s2_nxt.pix0     = s1_r.backdrop;
    s2_nxt.pix1     = (s1_r.vis != '0) ? s1_r.backdrop : '0;
    s2_nxt.semi     = s1_r.semi;
    s2_nxt.fx_allow = s1_r.fx_allow;
    for (int i = 0; i < NUM_LAYERS; i++) begin
      rank[i] = 3'd0;
      for (int j = 0; j < NUM_LAYERS; j++) begin
        if (s1_r.vis[j] && (s1_r.key[j] > s1_r.key[i])) begin
          rank[i] = rank[i] + 3'd1;
        end
      end
    end
    for (int i = 0; i < NUM_LAYERS; i++) begin
      if (s1_r.vis[i] && rank[i] == 3'd0) begin
        s2_nxt.top  = LAYER_W'(i);
        s2_nxt.pix0 = s1_r.col[i];
      end
      if (s1_r.vis[i] && rank[i] == 3'd1) begin
        s2_nxt.second = LAYER_W'(i);
        s2_nxt.pix1   = s1_r.col[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy) begin
      s2_r <= s2_nxt;
    end
  end

  // stage 3: effect mode and weight selection
  always_comb begin
    blend_mode_t         mode;
    logic                alpha_obj;
    logic                top_is_first;
    logic                second_is_tgt;
    logic [5:0]          first_mask;
    logic [5:0]          second_mask;
    logic [WEIGHT_W-1:0] evy;
    first_mask    = blend_ctl_r[5:0];
    second_mask   = blend_ctl_r[11:6];
    alpha_obj     = (s2_r.top == LAYER_SPRITE) && s2_r.semi;
    top_is_first  = first_mask[s2_r.top] || alpha_obj;
    second_is_tgt = second_mask[s2_r.second];
    mode          = blend_mode_t'(blend_ctl_r[13:12]);
    if (alpha_obj && second_is_tgt) begin
      mode = BLEND_ALPHA;
    end
    evy       = clamp_weight(blend_wt_r[14:10]);
    s3_nxt.top = s2_r.top;
    s3_nxt.c1  = s2_r.pix0;
    // pass-through: full weight on the top color
    s3_nxt.c2  = '0;
    s3_nxt.w1  = WEIGHT_FULL;
    s3_nxt.w2  = '0;
    if ((s2_r.fx_allow || alpha_obj) && top_is_first &&
        (second_is_tgt || mode != BLEND_ALPHA)) begin
      case (mode)
        BLEND_ALPHA: begin
          s3_nxt.c2 = s2_r.pix1;
          s3_nxt.w1 = clamp_weight(blend_wt_r[4:0]);
          s3_nxt.w2 = clamp_weight(blend_wt_r[9:5]);
        end
        BLEND_BRIGHTEN: begin
          s3_nxt.c2 = COLOR_WHITE;
          s3_nxt.w1 = WEIGHT_FULL - evy;
          s3_nxt.w2 = evy;
        end
        BLEND_DARKEN: begin
          s3_nxt.c2 = '0;
          s3_nxt.w1 = WEIGHT_FULL - evy;
          s3_nxt.w2 = evy;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s3_rdy) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy) begin
      s3_r <= s3_nxt;
    end
  end

  // stage 4: per-channel mix and argb packing
  always_comb begin
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
    r = mix_chan(s3_r.c1[4:0], s3_r.w1, s3_r.c2[4:0], s3_r.w2);
    g = mix_chan(s3_r.c1[9:5], s3_r.w1, s3_r.c2[9:5], s3_r.w2);
    b = mix_chan(s3_r.c1[14:10], s3_r.w1, s3_r.c2[14:10], s3_r.w2);
    color_nxt = {ALPHA_OPAQUE, r, 3'b000, g, 3'b000, b, 3'b000};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (s4_rdy) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_rdy) begin
      color_r <= color_nxt;
      top_r   <= s3_r.top;
    end
  end

  assign out_valid     = s4_valid_r;
  assign out_color     = color_r;
  assign out_top_layer = top_r;

`ifndef SYNTHESIS
  a_empty_never_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (!s1_valid_r && !s2_valid_r && !s3_valid_r && !s4_valid_r) |-> !in_stall)
    else $error("input stalled with an empty pipeline");

  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("transfer did not reach the output after four free cycles");

  a_backdrop_second: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_r.top == LAYER_BACKDROP) |-> (s2_r.second == LAYER_BACKDROP))
    else $error("second layer found without a top layer");

  a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
    s4_valid_r |-> (top_r <= LAYER_BACKDROP))
    else $error("top layer code out of range");
`endif

endmodule
